// ----- hw/rtl/block_range_minimum_query_defines.svh -----
// Assertion macros used by the bound checker in hw/rtl/brmq_checker.sv.
`ifndef BLOCK_RANGE_MINIMUM_QUERY_DEFINES_SVH
`define BLOCK_RANGE_MINIMUM_QUERY_DEFINES_SVH

// Same-cycle implication.
`define BRMQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BRMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/brmq_pkg.sv -----
`default_nettype none
package brmq_pkg;

   localparam int DEPTH_DEFAULT       = 16384;
   localparam int BLOCKS_DEFAULT      = 1024;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int INDEX_WIDTH    = 14;
   localparam int WALK_WIDTH     = INDEX_WIDTH + 1;
   localparam int FIELD_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int SHIFT_WIDTH    = 4;

   localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET = 4'd7;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_MIN   = 4'd4;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_MAX   = 4'd8;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } opcode_type;

   typedef enum logic {
      REG_BLOCK_SHIFT = 1'b0
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_PUT
   } state_type;

   typedef struct packed {
      opcode_type                    opcode;
      logic signed [FIELD_WIDTH-1:0] value;
      logic [INDEX_WIDTH-1:0]        first_index;
      logic [INDEX_WIDTH-1:0]        last_index;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] minimum;
      logic                          range_error;
   } rsp_type;

   typedef struct packed {
      logic append;
      logic clear;
      logic start;
      logic step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic query_error;
      logic walk_last;
      logic slot_free;
   } status_type;

   function automatic logic [SHIFT_WIDTH-1:0] clamp_shift(input logic [SHIFT_WIDTH-1:0] raw);
      logic [SHIFT_WIDTH-1:0] res;
      priority if (raw < SHIFT_MIN) begin
         res = SHIFT_MIN;
      end else if (raw > SHIFT_MAX) begin
         res = SHIFT_MAX;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/brmq_ram.sv -----
`default_nettype none
module brmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/brmq_ctrl.sv -----
`default_nettype none
module brmq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire brmq_pkg::opcode_type   req_opcode,
   output logic                        req_ready,
   input  wire brmq_pkg::status_type   status,
   output brmq_pkg::cmd_type           cmd
);
   import brmq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_opcode)
                  OP_APPEND: begin
                     cmd.append = 1'b1;
                  end
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  OP_QUERY: begin
                     cmd.start = 1'b1;
                     state_in  = status.query_error ? ST_PUT : ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (status.slot_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/brmq_dp.sv -----
`default_nettype none
module brmq_dp #(
   parameter int DEPTH       = brmq_pkg::DEPTH_DEFAULT,
   parameter int BLOCKS      = brmq_pkg::BLOCKS_DEFAULT,
   parameter int VALUE_WIDTH = brmq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                cfg_write,
   input  wire logic [brmq_pkg::SHIFT_WIDTH-1:0]    cfg_data,
   output logic      [brmq_pkg::SHIFT_WIDTH-1:0]    block_shift,
   input  wire brmq_pkg::req_type                   req_payload,
   input  wire brmq_pkg::cmd_type                   cmd,
   output brmq_pkg::status_type                     status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output brmq_pkg::rsp_type                        rsp_payload
);
   import brmq_pkg::*;

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BAW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int WW  = WALK_WIDTH;
   localparam int VW  = VALUE_WIDTH;

   logic [SHIFT_WIDTH-1:0] shift_ff, shift_in;
   logic [SHIFT_WIDTH-1:0] sh;
   logic [WW-1:0]          size, mask;

   logic [CW-1:0]          count_ff, count_in;
   logic signed [VW-1:0]   run_ff, run_in;
   logic signed [VW-1:0]   app_val;
   logic                   full, app_aligned, app_blk_ok, app_go;
   logic [CW-1:0]          app_blk;

   logic [WW-1:0]          i_ff, i_in;
   logic [INDEX_WIDTH-1:0] last_ff, last_in;
   logic                   err_ff, err_in;
   logic                   have_ff, have_in;
   logic                   pend_ff, pend_in;
   logic                   sel_ff, sel_in;
   logic signed [VW-1:0]   best_ff, best_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   aligned, blk_ok, fits, use_blk;
   logic [WW-1:0]          blk_w, next_i;
   logic signed [VW-1:0]   es_rd_data, bm_rd_data, rd_val;

   assign sh   = clamp_shift(shift_ff);
   assign size = {{(WW-1){1'b0}}, 1'b1} << sh;
   assign mask = size - {{(WW-1){1'b0}}, 1'b1};

   assign app_val     = VW'(req_payload.value);
   assign full        = (count_ff == CW'(DEPTH));
   assign app_aligned = ((count_ff & CW'(mask)) == '0);
   assign app_blk     = count_ff >> sh;
   assign app_blk_ok  = (32'(app_blk) < 32'(BLOCKS));
   assign app_go      = cmd.append & ~full;
   assign run_in      = (app_aligned || app_val < run_ff) ? app_val : run_ff;

   assign aligned = ((i_ff & mask) == '0);
   assign blk_w   = i_ff >> sh;
   assign blk_ok  = (32'(blk_w) < 32'(BLOCKS));
   assign fits    = ((i_ff + mask) <= WW'(last_ff));
   assign use_blk = aligned & fits & blk_ok;
   assign next_i  = use_blk ? (i_ff + size) : (i_ff + {{(WW-1){1'b0}}, 1'b1});

   assign rd_val = sel_ff ? bm_rd_data : es_rd_data;

   brmq_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_element_store (
      .clock   (clock),
      .wr_en   (app_go),
      .wr_addr (AW'(count_ff)),
      .wr_data (app_val),
      .rd_en   (cmd.step & ~use_blk),
      .rd_addr (AW'(i_ff)),
      .rd_data (es_rd_data)
   );

   brmq_ram #(.WIDTH(VW), .DEPTH(BLOCKS)) u_block_minima (
      .clock   (clock),
      .wr_en   (app_go & app_blk_ok),
      .wr_addr (BAW'(app_blk)),
      .wr_data (run_in),
      .rd_en   (cmd.step & use_blk),
      .rd_addr (BAW'(blk_w)),
      .rd_data (bm_rd_data)
   );

   always_comb begin
      shift_in     = shift_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      sel_in       = sel_ff;
      pend_in      = cmd.step;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      priority if (cfg_write) begin
         shift_in = cfg_data;
         count_in = '0;
      end else if (cmd.clear) begin
         count_in = '0;
      end else if (app_go) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd.start) begin
         i_in    = WW'(req_payload.first_index);
         last_in = req_payload.last_index;
         err_in  = status.query_error;
         have_in = 1'b0;
      end

      if (cmd.step) begin
         i_in   = next_i;
         sel_in = use_blk;
      end

      if (pend_ff) begin
         have_in = 1'b1;
         if (!have_ff || rd_val < best_ff) begin
            best_in = rd_val;
         end
      end

      if (cmd.load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.minimum     = err_ff ? '0 : FIELD_WIDTH'(best_ff);
         rsp_in.range_error = err_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= SHIFT_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (app_go) begin
         run_ff <= run_in;
      end
      i_ff    <= i_in;
      last_ff <= last_in;
      err_ff  <= err_in;
      sel_ff  <= sel_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   assign status.query_error = (req_payload.first_index > req_payload.last_index) ||
                               (32'(req_payload.last_index) >= 32'(count_ff));
   assign status.walk_last   = (next_i > WW'(last_ff));
   assign status.slot_free   = ~rsp_valid_ff | rsp_ready;

   assign block_shift = shift_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/block_range_minimum_query.sv -----
// Channel   Ports                                  Moves
// req       req_valid / req_ready / req_payload    append, query or clear beat
// rsp       rsp_valid / rsp_ready / rsp_payload    one beat per query
// csr       psel penable pwrite paddr pwdata ...   block_shift at byte address 0
//
// Append and clear leave the controller idle; the next beat is taken in the following cycle.
// A query walks head elements, then whole blocks, then tail elements,
// one read per cycle from the element store or the block-minimum store.
// An out-of-range query skips the walk and answers directly. Reset is synchronous; the stores
// need no clearing. A stalled result beat holds in the output register while
// appends and clears go on; a finished query waits for that register to empty.
`default_nettype none
module block_range_minimum_query #(
   parameter int DEPTH       = brmq_pkg::DEPTH_DEFAULT,
   parameter int BLOCKS      = brmq_pkg::BLOCKS_DEFAULT,
   parameter int VALUE_WIDTH = brmq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire brmq_pkg::req_type                    req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output brmq_pkg::rsp_type                         rsp_payload,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [brmq_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [brmq_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [brmq_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                      pready
);
   import brmq_pkg::*;

   cmd_type                cmd;
   status_type             status;
   logic                   reg_hit;
   logic                   cfg_write;
   logic [SHIFT_WIDTH-1:0] block_shift;

   assign reg_hit   = (paddr[CSR_ADDR_WIDTH-1] == REG_BLOCK_SHIFT);
   assign cfg_write = psel & penable & pwrite & pready & reg_hit;
   assign pready    = 1'b1;
   assign prdata    = reg_hit ? CSR_DATA_WIDTH'(block_shift) : '0;

   brmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   brmq_dp #(
      .DEPTH       (DEPTH),
      .BLOCKS      (BLOCKS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg_write   (cfg_write),
      .cfg_data    (pwdata[SHIFT_WIDTH-1:0]),
      .block_shift (block_shift),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/brmq_checker.sv -----
`default_nettype none
`include "block_range_minimum_query_defines.svh"
module brmq_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire brmq_pkg::req_type                    req_payload,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire brmq_pkg::rsp_type                    rsp_payload,
   input wire logic                                 psel,
   input wire logic                                 penable,
   input wire logic                                 pwrite,
   input wire logic [brmq_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input wire logic [brmq_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   input wire logic [brmq_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   input wire logic                                 pready
);
   import brmq_pkg::*;

   `BRMQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "result beat dropped or changed while stalled")

   `BRMQ_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_payload.range_error,
      rsp_payload.minimum == 0, "error beat carries a nonzero minimum")

   `BRMQ_ASSERT_NEXT(a_no_spurious, clock, reset,
      req_valid && req_ready && req_payload.opcode != OP_QUERY && (!rsp_valid || rsp_ready),
      !rsp_valid, "result beat without a query")

   `BRMQ_ASSERT_NEXT(a_csr_readback, clock, reset,
      psel && penable && pwrite && pready && !paddr[CSR_ADDR_WIDTH-1],
      paddr[CSR_ADDR_WIDTH-1] || prdata[SHIFT_WIDTH-1:0] == $past(pwdata[SHIFT_WIDTH-1:0]),
      "block_shift readback mismatch")

endmodule

bind block_range_minimum_query brmq_checker u_brmq_checker (.*);
`default_nettype wire

// ----- tb/brmq_checker.sv -----
`timescale 1ns / 100ps
module tb_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire brmq_pkg::req_type                    req_payload,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire brmq_pkg::rsp_type                    rsp_payload,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [brmq_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [brmq_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   input  wire logic                                 pready,
   output int                                        failures,
   output int                                        outstanding
);
   import brmq_pkg::*;

   localparam int DEPTH  = DEPTH_DEFAULT;
   localparam int BLOCKS = BLOCKS_DEFAULT;
   localparam logic [CSR_ADDR_WIDTH-1:0] SHIFT_ADDR = CSR_ADDR_WIDTH'(4 * REG_BLOCK_SHIFT);

   logic signed [FIELD_WIDTH-1:0] element_mem [DEPTH];
   logic signed [FIELD_WIDTH-1:0] block_min_mem [BLOCKS];
   logic [SHIFT_WIDTH-1:0]        shift_setting = SHIFT_RESET;
   int unsigned                   loaded = 0;
   int                            fail_total = 0;
   rsp_type                       minimum_q [$];

   function automatic int unsigned block_bits();
      if (shift_setting < SHIFT_MIN) return int'(SHIFT_MIN);
      if (shift_setting > SHIFT_MAX) return int'(SHIFT_MAX);
      return int'(shift_setting);
   endfunction

   function automatic void fold_append(input logic signed [FIELD_WIDTH-1:0] v);
      int unsigned bits;
      int unsigned blk;
      bits = block_bits();
      if (loaded >= DEPTH) return;
      element_mem[loaded] = v;
      blk = loaded >> bits;
      if (blk < BLOCKS && ((loaded & ((1 << bits) - 1)) == 0 || v < block_min_mem[blk]))
         block_min_mem[blk] = v;
      loaded++;
   endfunction

   function automatic logic signed [FIELD_WIDTH-1:0] range_minimum(input int unsigned first,
                                                                   input int unsigned last);
      int unsigned bits;
      int unsigned span;
      int unsigned pos;
      int unsigned k;
      logic signed [FIELD_WIDTH-1:0] best;
      bits = block_bits();
      span = 1 << bits;
      pos  = first;
      best = element_mem[first];
      while (pos <= last && (pos & (span - 1)) != 0) begin
         if (element_mem[pos] < best) best = element_mem[pos];
         pos++;
      end
      while (pos + span - 1 <= last) begin
         if ((pos >> bits) < BLOCKS) begin
            if (block_min_mem[pos >> bits] < best) best = block_min_mem[pos >> bits];
         end else begin
            // scan a block that has no minimum entry
            for (k = pos; k < pos + span; k++)
               if (element_mem[k] < best) best = element_mem[k];
         end
         pos += span;
      end
      while (pos <= last) begin
         if (element_mem[pos] < best) best = element_mem[pos];
         pos++;
      end
      return best;
   endfunction

   function automatic rsp_type predict_query(input req_type beat);
      rsp_type r;
      r.minimum     = '0;
      r.range_error = 1'b1;
      if (beat.first_index <= beat.last_index && int'(beat.last_index) < int'(loaded)) begin
         r.minimum     = range_minimum(int'(beat.first_index), int'(beat.last_index));
         r.range_error = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         shift_setting = SHIFT_RESET;
         loaded        = 0;
         minimum_q.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == SHIFT_ADDR) begin
            shift_setting = pwdata[SHIFT_WIDTH-1:0];
            loaded        = 0;
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (minimum_q.size() == 0) begin
               $error("result beat with no query waiting: minimum %0d, range_error %0b",
                      $signed(got.minimum), got.range_error);
               fail_total++;
            end else begin
               want = minimum_q.pop_front();
               if (got.minimum !== want.minimum) begin
                  $error("minimum: expected %0d, got %0d",
                         $signed(want.minimum), $signed(got.minimum));
                  fail_total++;
               end
               if (got.range_error !== want.range_error) begin
                  $error("range_error: expected %0b, got %0b",
                         want.range_error, got.range_error);
                  fail_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_payload.opcode)
               OP_APPEND: fold_append(req_payload.value);
               OP_QUERY:  minimum_q.push_back(predict_query(req_payload));
               OP_CLEAR:  loaded = 0;
               default: ;
            endcase
         end
      end
      failures    <= fail_total;
      outstanding <= minimum_q.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
   import brmq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam logic [CSR_ADDR_WIDTH-1:0] SHIFT_ADDR = CSR_ADDR_WIDTH'(4 * REG_BLOCK_SHIFT);
   localparam opcode_type OP_UNUSED = opcode_type'(2'd3);

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_payload;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;
   int                        failures;
   int                        outstanding;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int unsigned loaded = 0;
   int          cycle_count = 0;

   block_range_minimum_query i_dut (.*);

   tb_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   function automatic req_type make_beat(input opcode_type op,
                                         input logic signed [FIELD_WIDTH-1:0] value,
                                         input int unsigned first, input int unsigned last);
      req_type b;
      b.opcode      = op;
      b.value       = value;
      b.first_index = first[INDEX_WIDTH-1:0];
      b.last_index  = last[INDEX_WIDTH-1:0];
      case (op)
         OP_APPEND: if (loaded < DEPTH) loaded++;
         OP_CLEAR:  loaded = 0;
         default: ;
      endcase
      return b;
   endfunction

   function automatic logic signed [FIELD_WIDTH-1:0] pick_value();
      case ($urandom_range(3))
         0:       return $urandom_range(40) - 20;
         1:       return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type append_beat();
      return make_beat(OP_APPEND, pick_value(), $urandom_range(DEPTH - 1),
                       $urandom_range(DEPTH - 1));
   endfunction

   function automatic req_type query_beat();
      int unsigned pick;
      int unsigned first;
      int unsigned last;
      pick  = $urandom_range(9);
      first = $urandom_range(DEPTH - 1);
      last  = $urandom_range(DEPTH - 1);
      if (pick == 1) begin
         last  = $urandom_range(DEPTH - 2);
         first = $urandom_range(DEPTH - 1, last + 1);
      end else if (pick == 2 && loaded < DEPTH) begin
         last  = $urandom_range(DEPTH - 1, loaded);
         first = $urandom_range(last);
      end else if (pick >= 3 && loaded > 0) begin
         last = $urandom_range(loaded - 1);
         case (pick)
            3, 4: first = last - $urandom_range(last < 20 ? last : 20);
            5: begin
               first = 0;
               last  = loaded - 1;
            end
            default: first = $urandom_range(last);
         endcase
      end
      return make_beat(OP_QUERY, $urandom, first, last);
   endfunction

   function automatic req_type mixed_beat(input logic allow_clear);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 2 && allow_clear)
         return make_beat(OP_CLEAR, $urandom, $urandom_range(DEPTH - 1),
                          $urandom_range(DEPTH - 1));
      if (pick < 3)
         return make_beat(OP_UNUSED, $urandom, $urandom_range(DEPTH - 1),
                          $urandom_range(DEPTH - 1));
      if (pick < 50)
         return append_beat();
      return query_beat();
   endfunction

   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_shift(input logic [SHIFT_WIDTH-1:0] shift);
      logic [CSR_DATA_WIDTH-1:0] data;
      data                  = $urandom;
      data[SHIFT_WIDTH-1:0] = shift;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SHIFT_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      loaded = 0;
   endtask

   task automatic run_segment(input logic [SHIFT_WIDTH-1:0] shift, input int load_max,
                              input int mixed);
      settle();
      write_shift(shift);
      repeat ($urandom_range(load_max, 16)) send_beat(append_beat());
      repeat (mixed) send_beat(mixed_beat(1'b1));
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      recv_idle_pct = 74;

      // reset block size, empty array, value extremes, bad ranges
      send_beat(make_beat(OP_QUERY, 0, 0, 0));
      send_beat(make_beat(OP_APPEND, 32'sh8000_0000, 14'h3fff, 14'h3fff));
      send_beat(make_beat(OP_APPEND, 32'sh7fff_ffff, 0, 0));
      send_beat(make_beat(OP_APPEND, 0, 0, 0));
      send_beat(make_beat(OP_APPEND, -1, 0, 0));
      send_beat(make_beat(OP_APPEND, 1, 0, 0));
      send_beat(make_beat(OP_QUERY, -1, 0, 4));
      send_beat(make_beat(OP_QUERY, 0, 1, 1));
      send_beat(make_beat(OP_QUERY, 0, 2, 4));
      send_beat(make_beat(OP_QUERY, 0, 3, 2));
      send_beat(make_beat(OP_QUERY, 0, 0, 5));
      send_beat(make_beat(OP_QUERY, 0, 16383, 16383));
      send_beat(make_beat(OP_QUERY, 0, 0, 16383));
      send_beat(make_beat(OP_UNUSED, -1, 16383, 16383));
      send_beat(make_beat(OP_QUERY, 0, 4, 4));
      send_beat(make_beat(OP_CLEAR, 0, 0, 0));
      send_beat(make_beat(OP_QUERY, 0, 0, 0));
      send_beat(make_beat(OP_APPEND, 32'sh7fff_ffff, 0, 0));
      send_beat(make_beat(OP_QUERY, 0, 0, 0));
      send_beat(make_beat(OP_APPEND, 32'sh8000_0000, 0, 0));
      send_beat(make_beat(OP_QUERY, 0, 0, 1));
      send_beat(make_beat(OP_QUERY, 0, 1, 0));

      run_segment(SHIFT_MIN, 150, 70);
      run_segment(4'hf, 350, 70);

      send_idle_pct = 74;
      recv_idle_pct = 33;
      run_segment(4'h0, 150, 70);
      run_segment(SHIFT_WIDTH'($urandom_range(6, 5)), 250, 70);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_segment(SHIFT_RESET, 150, 70);
      run_segment(SHIFT_MAX, 250, 70);

      run_segment(SHIFT_WIDTH'($urandom_range(15)), 150, 70);

      settle();
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- block_range_minimum_query.f -----
+incdir+hw/rtl
hw/rtl/brmq_pkg.sv
hw/rtl/brmq_ram.sv
hw/rtl/brmq_ctrl.sv
hw/rtl/brmq_dp.sv
hw/rtl/block_range_minimum_query.sv
hw/rtl/brmq_checker.sv
tb/brmq_checker.sv
tb/tb_top.sv
